// ===== hdl/engine_plant_sim_step_top_assert.svh =====
// ----------------------------------------------------------------------------
// Engine plant step assertion macros
// Shorthand for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef ENGINE_PLANT_SIM_STEP_TOP_ASSERT_SVH
`define ENGINE_PLANT_SIM_STEP_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define EPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("engine plant step: property violated");

// Consequent must hold in the cycle after the antecedent.
`define EPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("engine plant step: property violated");

`endif

// ===== hdl/eps_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant step package
// Widths, fixed-point constants, microcode word layout and shared types.
// ----------------------------------------------------------------------------
package eps_pkg;

  localparam int TPS_W       = 14;
  localparam int EGT_W       = 14;
  localparam int RPM_W       = 15;
  localparam int PICK_W      = 9;
  localparam int PCT_W       = 14;
  localparam int SPD_ACC_W   = 31;
  localparam int EGT_ACC_W   = 30;
  localparam int TGT_W       = 33;
  localparam int MUL_W       = 33;
  localparam int PROD_W      = 66;
  localparam int STEP_W      = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 15;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 72;

  localparam logic [TPS_W-1:0] TPS_MAX  = 14'd10000;
  localparam logic [RPM_W-1:0] RPM_MAX  = 15'd18000;
  localparam logic [RPM_W-1:0] RPM_BASE = 15'd1200;
  localparam logic [EGT_W-1:0] EGT_MIN  = 14'd200;
  localparam logic [EGT_W-1:0] EGT_MAX  = 14'd10000;
  localparam logic [PCT_W-1:0] PCT_MAX  = 14'd10000;

  // Accumulator values in Q.16.
  localparam logic [SPD_ACC_W-1:0] SPD_RESET      = 31'd78643200;
  localparam logic [EGT_ACC_W-1:0] EGT_RESET      = 30'd13107200;
  localparam logic signed [33:0]   SPD_MAX_Q      = 34'sd1179648000;
  localparam logic signed [33:0]   EGT_MIN_Q      = 34'sd13107200;
  localparam logic signed [33:0]   EGT_MAX_Q      = 34'sd655360000;
  localparam logic signed [TGT_W-1:0] EGT_FAULT_Q = 33'sd557056000;

  // Q0.16 lag gains.
  localparam logic signed [MUL_W-1:0] GAIN_RPM     = 33'sd1311;
  localparam logic signed [MUL_W-1:0] GAIN_FAULT   = 33'sd3277;
  localparam logic signed [MUL_W-1:0] GAIN_THERMAL = 33'sd328;

  // Reciprocals for exact division by constants over the value ranges used:
  // x/25 = (x*R25)>>23, x/15 = (x*R15)>>20, x/5 = (x*R5)>>34, x/9 = (x*R9)>>24.
  localparam logic signed [MUL_W-1:0] RECIP_25 = 33'sd335545;
  localparam logic signed [MUL_W-1:0] RECIP_15 = 33'sd69906;
  localparam logic signed [MUL_W-1:0] RECIP_5  = 33'sd3435973837;
  localparam logic signed [MUL_W-1:0] RECIP_9  = 33'sd1864136;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TPS_OVR_EN  = 3'd0,
    CFG_TPS_OVR_VAL = 3'd1,
    CFG_RPM_OVR_EN  = 3'd2,
    CFG_RPM_OVR_VAL = 3'd3,
    CFG_EGT_OVR_EN  = 3'd4,
    CFG_EGT_OVR_VAL = 3'd5,
    CFG_OVERHEAT    = 3'd6
  } cfg_idx_t;

  typedef struct packed {
    logic             tps_ovr_en;
    logic [TPS_W-1:0] tps_ovr_val;
    logic             rpm_ovr_en;
    logic [RPM_W-1:0] rpm_ovr_val;
    logic             egt_ovr_en;
    logic [EGT_W-1:0] egt_ovr_val;
    logic             overheat;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    tps_ovr_en:  1'b0,
    tps_ovr_val: '0,
    rpm_ovr_en:  1'b0,
    rpm_ovr_val: 15'd1200,
    egt_ovr_en:  1'b0,
    egt_ovr_val: 14'd200,
    overheat:    1'b0
  };

  typedef enum logic [2:0] {
    MS_TPS_DIV25,
    MS_SPD_LAG,
    MS_PICKUP,
    MS_SPARK,
    MS_EGT_THERM,
    MS_EGT_FAULT,
    MS_PCT
  } mul_src_t;

  typedef enum logic [3:0] {
    WB_NONE,
    WB_SPD_TGT,
    WB_SPD_UPD,
    WB_SPD_FORCE,
    WB_PICKUP,
    WB_FAULT_TGT,
    WB_BASE_TGT,
    WB_ADD_SPARK,
    WB_EGT_UPD,
    WB_EGT_FORCE
  } wb_t;

  typedef enum logic [2:0] {
    BR_NEXT,
    BR_JUMP,
    BR_RPM_OVR,
    BR_EGT_OVR,
    BR_FAULT,
    BR_END
  } br_t;

  typedef struct packed {
    logic              mul_en;
    mul_src_t          mul_src;
    wb_t               wb;
    br_t               br;
    logic [STEP_W-1:0] target;
  } ctl_word_t;

  // First member ends up in the top bits, so rpm lands lowest.
  typedef struct packed {
    logic [PCT_W-1:0]  pct;
    logic [PICK_W-1:0] pickup;
    logic [EGT_W-1:0]  egt;
    logic [TPS_W-1:0]  tps;
    logic [RPM_W-1:0]  rpm;
  } result_t;

  // floor(r * 168 * 65536 / 100) for r = 0..24, the fractional part of the
  // speed target once the throttle is split into 25*q + r.
  function automatic logic [21:0] spd_frac_lut(input logic [4:0] r);
    logic [21:0] v;
    case (r)
      5'd0:    v = 22'd0;
      5'd1:    v = 22'd110100;
      5'd2:    v = 22'd220200;
      5'd3:    v = 22'd330301;
      5'd4:    v = 22'd440401;
      5'd5:    v = 22'd550502;
      5'd6:    v = 22'd660602;
      5'd7:    v = 22'd770703;
      5'd8:    v = 22'd880803;
      5'd9:    v = 22'd990904;
      5'd10:   v = 22'd1101004;
      5'd11:   v = 22'd1211105;
      5'd12:   v = 22'd1321205;
      5'd13:   v = 22'd1431306;
      5'd14:   v = 22'd1541406;
      5'd15:   v = 22'd1651507;
      5'd16:   v = 22'd1761607;
      5'd17:   v = 22'd1871708;
      5'd18:   v = 22'd1981808;
      5'd19:   v = 22'd2091909;
      5'd20:   v = 22'd2202009;
      5'd21:   v = 22'd2312110;
      5'd22:   v = 22'd2422210;
      5'd23:   v = 22'd2532311;
      5'd24:   v = 22'd2642411;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/eps_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant step microsequencer
// Step counter, microcode ROM and conditional branching for one tick.
// ----------------------------------------------------------------------------
module eps_sequencer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               out_free,
  input  eps_pkg::cfg_t      cfg,
  output eps_pkg::ctl_word_t ctl,
  output logic               busy,
  output logic               step_en,
  output logic               done
);
  import eps_pkg::*;

  logic              busy_r, busy_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              take;

  function automatic ctl_word_t ucode(input logic [STEP_W-1:0] s);
    ctl_word_t w;
    w = '{mul_en: 1'b0, mul_src: MS_TPS_DIV25, wb: WB_NONE, br: BR_NEXT, target: '0};
    unique case (s)
      4'd0: begin
        w.mul_en = 1'b1; w.mul_src = MS_TPS_DIV25;
      end
      4'd1: begin
        w.wb = WB_SPD_TGT; w.br = BR_RPM_OVR; w.target = 4'd4;
      end
      4'd2: begin
        w.mul_en = 1'b1; w.mul_src = MS_SPD_LAG;
      end
      4'd3: begin
        w.wb = WB_SPD_UPD; w.br = BR_JUMP; w.target = 4'd5;
      end
      4'd4: begin
        w.wb = WB_SPD_FORCE;
      end
      4'd5: begin
        w.mul_en = 1'b1; w.mul_src = MS_PICKUP;
      end
      4'd6: begin
        w.wb = WB_PICKUP; w.br = BR_EGT_OVR; w.target = 4'd13;
      end
      4'd7: begin
        w.wb = WB_FAULT_TGT; w.br = BR_FAULT; w.target = 4'd11;
      end
      4'd8: begin
        w.mul_en = 1'b1; w.mul_src = MS_SPARK; w.wb = WB_BASE_TGT;
      end
      4'd9: begin
        w.wb = WB_ADD_SPARK;
      end
      4'd10: begin
        w.mul_en = 1'b1; w.mul_src = MS_EGT_THERM; w.br = BR_JUMP; w.target = 4'd12;
      end
      4'd11: begin
        w.mul_en = 1'b1; w.mul_src = MS_EGT_FAULT;
      end
      4'd12: begin
        w.wb = WB_EGT_UPD; w.br = BR_JUMP; w.target = 4'd14;
      end
      4'd13: begin
        w.wb = WB_EGT_FORCE;
      end
      4'd14: begin
        w.mul_en = 1'b1; w.mul_src = MS_PCT;
      end
      4'd15: begin
        w.br = BR_END;
      end
      default: begin
        w.br = BR_END;
      end
    endcase
    return w;
  endfunction

  always_comb begin
    ctl     = ucode(step_r);
    step_en = busy_r && ((ctl.br != BR_END) || out_free);
    done    = step_en && (ctl.br == BR_END);
    busy    = busy_r;
  end

  always_comb begin
    unique case (ctl.br)
      BR_JUMP:    take = 1'b1;
      BR_RPM_OVR: take = cfg.rpm_ovr_en;
      BR_EGT_OVR: take = cfg.egt_ovr_en;
      BR_FAULT:   take = cfg.overheat;
      default:    take = 1'b0;
    endcase
  end

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    if (step_en) begin
      step_nxt = take ? ctl.target : step_r + STEP_W'(1);
    end
    if (done) begin
      busy_nxt = 1'b0;
    end
    // A new tick may start on the same edge that the previous one finishes.
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
  end

endmodule

// ===== hdl/eps_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant step datapath
// Plant state, one shared multiplier and the write-back operations it feeds.
// ----------------------------------------------------------------------------
module eps_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        load,
  input  logic [eps_pkg::TPS_W-1:0]   in_tps,
  input  logic [eps_pkg::EGT_W-1:0]   in_egt,
  input  logic                        in_spark,
  input  eps_pkg::cfg_t               cfg,
  input  eps_pkg::ctl_word_t          ctl,
  input  logic                        step_en,
  output eps_pkg::result_t            res
);
  import eps_pkg::*;

  logic [SPD_ACC_W-1:0]     spd_acc_r, spd_acc_nxt;
  logic [EGT_ACC_W-1:0]     egt_acc_r, egt_acc_nxt;
  logic signed [TGT_W-1:0]  tgt_r, tgt_nxt;
  logic signed [PROD_W-1:0] prod_r, prod_nxt;
  logic [PICK_W-1:0]        pick_r, pick_nxt;
  logic [TPS_W-1:0]         tps_r;
  logic [EGT_W-1:0]         base_r;
  logic                     spark_r;

  logic [TPS_W-1:0]         tps_act, tps_clip;
  logic [EGT_W-1:0]         egt_clip, egt_force;
  logic [RPM_W-1:0]         rpm_force;
  logic signed [TGT_W-1:0]  spd_diff, egt_diff;
  logic [32:0]              spark_sum, egt_x5;
  logic signed [MUL_W-1:0]  a_op, b_op;

  logic [8:0]               quot25;
  logic [TPS_W-1:0]         mul25, rem_full;
  logic [RPM_W-1:0]         spd_base;
  logic signed [TGT_W-1:0]  spd_tgt;
  logic signed [31:0]       lag_q;
  logic signed [33:0]       spd_sum, egt_sum;
  logic [SPD_ACC_W-1:0]     spd_clamp;
  logic [EGT_ACC_W-1:0]     egt_clamp;
  logic [17:0]              pct_raw;

  // Input capture: active throttle and clamped baseline.
  always_comb begin
    tps_act  = cfg.tps_ovr_en ? cfg.tps_ovr_val : in_tps;
    tps_clip = (tps_act > TPS_MAX) ? TPS_MAX : tps_act;
    if (in_egt < EGT_MIN) begin
      egt_clip = EGT_MIN;
    end else if (in_egt > EGT_MAX) begin
      egt_clip = EGT_MAX;
    end else begin
      egt_clip = in_egt;
    end
  end

  // Multiplier operand selection.
  always_comb begin
    spd_diff  = tgt_r - $signed({2'b00, spd_acc_r});
    egt_diff  = tgt_r - $signed({3'b000, egt_acc_r});
    spark_sum = {1'b0, tps_r, 18'd0} + {2'b00, spd_acc_r} + {1'b0, spd_acc_r, 1'b0};
    egt_x5    = {1'b0, egt_acc_r, 2'b00} + {3'b000, egt_acc_r};
    case (ctl.mul_src)
      MS_TPS_DIV25: begin
        a_op = $signed({19'd0, tps_r});
        b_op = RECIP_25;
      end
      MS_SPD_LAG: begin
        a_op = spd_diff;
        b_op = GAIN_RPM;
      end
      MS_PICKUP: begin
        // rpm/60 taken as (rpm/4)/15
        a_op = $signed({20'd0, spd_acc_r[30:18]});
        b_op = RECIP_15;
      end
      MS_SPARK: begin
        // x/10 taken as (x/2)/5
        a_op = $signed({1'b0, spark_sum[32:1]});
        b_op = RECIP_5;
      end
      MS_EGT_THERM: begin
        a_op = egt_diff;
        b_op = GAIN_THERMAL;
      end
      MS_EGT_FAULT: begin
        a_op = egt_diff;
        b_op = GAIN_FAULT;
      end
      MS_PCT: begin
        // acc*10/(9*65536) taken as ((acc*5)>>15)/9
        a_op = $signed({15'd0, egt_x5[32:15]});
        b_op = RECIP_9;
      end
      default: begin
        a_op = '0;
        b_op = '0;
      end
    endcase
    prod_nxt = a_op * b_op;
  end

  // Write-back arithmetic on the registered product.
  always_comb begin
    quot25   = prod_r[31:23];
    mul25    = {1'b0, quot25, 4'd0} + {2'b00, quot25, 3'd0} + {5'd0, quot25};
    rem_full = tps_r - mul25;
    spd_base = RPM_BASE + {1'b0, quot25, 5'd0} + {3'b000, quot25, 3'd0}
             + {5'd0, quot25, 1'b0};
    spd_tgt  = $signed({2'b00, spd_base, 16'd0})
             + $signed({11'd0, spd_frac_lut(rem_full[4:0])});

    // Upper product bits give the floor of the signed product over 65536.
    lag_q   = $signed(prod_r[47:16]);
    spd_sum = $signed({3'b000, spd_acc_r}) + $signed({{2{lag_q[31]}}, lag_q});
    egt_sum = $signed({4'b0000, egt_acc_r}) + $signed({{2{lag_q[31]}}, lag_q});

    if (spd_sum < 34'sd0) begin
      spd_clamp = '0;
    end else if (spd_sum > SPD_MAX_Q) begin
      spd_clamp = SPD_MAX_Q[SPD_ACC_W-1:0];
    end else begin
      spd_clamp = spd_sum[SPD_ACC_W-1:0];
    end

    if (egt_sum < EGT_MIN_Q) begin
      egt_clamp = EGT_MIN_Q[EGT_ACC_W-1:0];
    end else if (egt_sum > EGT_MAX_Q) begin
      egt_clamp = EGT_MAX_Q[EGT_ACC_W-1:0];
    end else begin
      egt_clamp = egt_sum[EGT_ACC_W-1:0];
    end

    rpm_force = (cfg.rpm_ovr_val > RPM_MAX) ? RPM_MAX : cfg.rpm_ovr_val;
    if (cfg.egt_ovr_val < EGT_MIN) begin
      egt_force = EGT_MIN;
    end else if (cfg.egt_ovr_val > EGT_MAX) begin
      egt_force = EGT_MAX;
    end else begin
      egt_force = cfg.egt_ovr_val;
    end

    spd_acc_nxt = spd_acc_r;
    egt_acc_nxt = egt_acc_r;
    tgt_nxt     = tgt_r;
    pick_nxt    = pick_r;
    case (ctl.wb)
      WB_SPD_TGT:   tgt_nxt = spd_tgt;
      WB_SPD_UPD:   spd_acc_nxt = spd_clamp;
      WB_SPD_FORCE: spd_acc_nxt = {rpm_force, 16'd0};
      WB_PICKUP:    pick_nxt = prod_r[28:20];
      WB_FAULT_TGT: tgt_nxt = EGT_FAULT_Q;
      WB_BASE_TGT:  tgt_nxt = $signed({3'b000, base_r, 16'd0});
      WB_ADD_SPARK: begin
        if (spark_r) begin
          tgt_nxt = tgt_r + $signed({3'b000, prod_r[63:34]});
        end
      end
      WB_EGT_UPD:   egt_acc_nxt = egt_clamp;
      WB_EGT_FORCE: egt_acc_nxt = {egt_force, 16'd0};
      default: ;
    endcase

    pct_raw = prod_r[41:24];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_acc_r <= SPD_RESET;
      egt_acc_r <= EGT_RESET;
    end else if (step_en) begin
      spd_acc_r <= spd_acc_nxt;
      egt_acc_r <= egt_acc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      tps_r   <= tps_clip;
      base_r  <= egt_clip;
      spark_r <= in_spark;
    end
    if (step_en) begin
      tgt_r  <= tgt_nxt;
      pick_r <= pick_nxt;
      if (ctl.mul_en) begin
        prod_r <= prod_nxt;
      end
    end
  end

  // The percentage is read straight off the product on the final step.
  always_comb begin
    res.rpm    = spd_acc_r[30:16];
    res.tps    = tps_r;
    res.egt    = egt_acc_r[29:16];
    res.pickup = pick_r;
    res.pct    = (pct_raw > {4'd0, PCT_MAX}) ? PCT_MAX : pct_raw[PCT_W-1:0];
  end

endmodule

// ===== hdl/engine_plant_sim_step_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant step, top level
// Advances an engine speed and exhaust temperature model by one tick per
// input transaction and reports speed, throttle, temperature, pickup
// frequency and temperature percentage.
// ----------------------------------------------------------------------------
// Each input transaction is one 10 ms tick and yields exactly one result
// transaction. A tick runs through a 16-step microprogram that drives one
// shared 33 x 33 multiplier, one step per clock, though the final step waits
// while the output register is still full; the rpm and temperature overrides
// and the overheat ramp skip steps. The next tick is accepted on the same
// edge on which the previous result moves into the output register.
// Configuration writes take effect at once and should be made between ticks.
module engine_plant_sim_step_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // tdata: tps_sample[13:0], egt_sample[27:14], zero fill [31:28]
  input  logic [eps_pkg::IN_TDATA_W-1:0]    in_tdata,
  // tuser: spark_present
  input  logic                              in_tuser,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // tdata: rpm_out[14:0], tps_out[28:15], egt_out[42:29],
  //        pickup_freq_hz[51:43], egt_pct[65:52], zero fill [71:66]
  output logic [eps_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  input  logic                              cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eps_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import eps_pkg::*;

  cfg_t      cfg_r, cfg_nxt;
  ctl_word_t ctl;
  result_t   res;
  result_t   out_data_r;
  logic      out_valid_r, out_valid_nxt;
  logic      busy, step_en, done, out_free, in_accept;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_TPS_OVR_EN:  cfg_nxt.tps_ovr_en  = cfg_wdata[0];
        CFG_TPS_OVR_VAL: cfg_nxt.tps_ovr_val = cfg_wdata[TPS_W-1:0];
        CFG_RPM_OVR_EN:  cfg_nxt.rpm_ovr_en  = cfg_wdata[0];
        CFG_RPM_OVR_VAL: cfg_nxt.rpm_ovr_val = cfg_wdata[RPM_W-1:0];
        CFG_EGT_OVR_EN:  cfg_nxt.egt_ovr_en  = cfg_wdata[0];
        CFG_EGT_OVR_VAL: cfg_nxt.egt_ovr_val = cfg_wdata[EGT_W-1:0];
        CFG_OVERHEAT:    cfg_nxt.overheat    = cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = !busy || done;
  assign in_accept = in_tvalid && in_tready;

  eps_sequencer u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_accept),
    .out_free (out_free),
    .cfg      (cfg_r),
    .ctl      (ctl),
    .busy     (busy),
    .step_en  (step_en),
    .done     (done)
  );

  eps_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_accept),
    .in_tps   (in_tdata[TPS_W-1:0]),
    .in_egt   (in_tdata[TPS_W+EGT_W-1:TPS_W]),
    .in_spark (in_tuser),
    .cfg      (cfg_r),
    .ctl      (ctl),
    .step_en  (step_en),
    .res      (res)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (done) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), out_data_r};

endmodule

// ===== hdl/eps_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Engine plant step checker
// Port-level properties of the top level, attached by a bind statement.
// ----------------------------------------------------------------------------
module eps_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [eps_pkg::OUT_TDATA_W-1:0] out_tdata
);
  `include "engine_plant_sim_step_top_assert.svh"

  // A pending result is held until the sink takes it.
  `EPS_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid)

  // Once a tick is taken the block is busy on the following cycle.
  `EPS_ASSERT_NEXT(a_busy_after_accept, in_tvalid && in_tready, !in_tready)

  // A fresh result comes only at the end of a tick that was being worked on.
  `EPS_ASSERT_NOW(a_result_after_work, $rose(out_tvalid), !$past(in_tready, 2))

  // Every reported field stays inside its physical range.
  `EPS_ASSERT_NOW(a_result_range, out_tvalid, (out_tdata[14:0] <= 15'd18000) && (out_tdata[28:15] <= 14'd10000) && (out_tdata[42:29] >= 14'd200) && (out_tdata[42:29] <= 14'd10000) && (out_tdata[51:43] <= 9'd300) && (out_tdata[65:52] <= 14'd10000))

endmodule

bind engine_plant_sim_step_top eps_checker u_eps_checker (.*);
